[src/assert_macros.svh]
// Assertion helpers for the block; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition implies another one in the same cycle.
`define TVP_ASSERT_SAME(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("same-cycle check failed");
// Check that a condition implies another one in the next cycle.
`define TVP_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TVP_ASSERT_SAME(lbl, ant, cons)
`define TVP_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

[src/tvp_pkg.sv]
package tvp_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_POSITION = 2'd0;
    localparam logic [1:0] CFG_MAX_SPEED       = 2'd1;
    localparam logic [1:0] CFG_ACCEL_RATE      = 2'd2;
    localparam logic [1:0] CFG_DECEL_RATE      = 2'd3;

    // Reset deceleration: -1.0 in Q16.16
    localparam logic [31:0] DECEL_RESET = 32'hFFFF_0000;

    // Number of quotient bits produced by the divider
    localparam int DIV_BITS = 32;

    typedef struct packed {
        logic signed [31:0] measured_position;
        logic        [15:0] time_step;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_velocity;
        logic signed [31:0] accel_estimate;
        logic               step_was_zero;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DIST,
        S_MUL_STOP,
        S_DECIDE,
        S_MUL_RATE,
        S_UPDATE,
        S_DIFF,
        S_DIV_SETUP,
        S_DIV,
        S_FINISH
    } state_t;

endpackage

[src/trapezoidal_velocity_profile.sv]
// Trapezoidal velocity profile generator in Q16.16. Each transaction on the
// input carries the measured position and the time step (Q0.16 seconds); the
// block updates its held velocity (brake when the remaining distance is at most
// v*v/|decel|, else accelerate and clamp at max_speed) and returns the new
// velocity with the acceleration estimate (velocity change / time step). An
// item makes three passes through one shared 32x32 multiplier with the update
// steps between them, then goes through a restoring divider that produces one
// quotient bit per cycle. A zero time step or a quotient of 2^32 or more skips
// the divider. The input is ready only while no item is in work, so a new item
// is taken only after the last one has left its final step. A finished result
// waits in the output register and does not block the next input; that next
// item holds at its last step until the register frees. Configuration writes
// take effect at once and belong in idle time.
`include "assert_macros.svh"

module trapezoidal_velocity_profile (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  tvp_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output tvp_pkg::out_t  out_data,
    input  logic           cfg_write_en,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    localparam int CNT_W = $clog2(tvp_pkg::DIV_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tvp_pkg::DIV_BITS - 1);

    // Control and state registers
    tvp_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     target_reg;
    logic [30:0]     max_speed_reg;
    logic [30:0]     accel_reg;
    logic [31:0]     decel_reg;
    logic [31:0]     held_reg, held_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Datapath registers
    logic [31:0]     rem_reg, rem_next;
    logic [31:0]     vm_reg, vm_next;
    logic [31:0]     dm_reg, dm_next;
    logic [15:0]     step_reg, step_next;
    logic [63:0]     prod_reg, prod_next;
    logic [63:0]     dist_reg, dist_next;
    logic            brake_reg, brake_next;
    logic [31:0]     nv_reg, nv_next;
    logic [32:0]     dmag_reg, dmag_next;
    logic            dneg_reg, dneg_next;
    logic            ovf_reg, ovf_next;
    logic [15:0]     drem_reg, drem_next;
    logic [31:0]     shreg_reg, shreg_next;
    tvp_pkg::out_t   out_reg, out_next;

    // Shared multiplier operands
    logic [31:0]     mul_a, mul_b;

    // Intermediate values
    logic [32:0]     pos_diff;
    logic [31:0]     rate_m;
    logic [33:0]     v_ext;
    logic [33:0]     m_ext;
    logic [33:0]     brake_sum;
    logic [33:0]     accel_sum;
    logic [32:0]     vel_diff;
    logic [16:0]     trial;
    logic            trial_ge;
    logic            q_big;
    logic [31:0]     acc_val;

    assign in_ready  = (state_reg == tvp_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        held_next      = held_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        vm_next        = vm_reg;
        dm_next        = dm_reg;
        step_next      = step_reg;
        dist_next      = dist_reg;
        brake_next     = brake_reg;
        nv_next        = nv_reg;
        dmag_next      = dmag_reg;
        dneg_next      = dneg_reg;
        ovf_next       = ovf_reg;
        drem_next      = drem_reg;
        shreg_next     = shreg_reg;
        out_next       = out_reg;
        mul_a          = rem_reg;
        mul_b          = dm_reg;

        pos_diff  = {target_reg[31], target_reg}
                  - {in_data.measured_position[31], in_data.measured_position};
        rate_m    = prod_reg[47:16];
        v_ext     = {{2{held_reg[31]}}, held_reg};
        m_ext     = {2'b00, rate_m};
        brake_sum = decel_reg[31] ? (v_ext - m_ext) : (v_ext + m_ext);
        accel_sum = v_ext + m_ext;
        vel_diff  = {nv_reg[31], nv_reg} - {held_reg[31], held_reg};
        trial     = {drem_reg, shreg_reg[31]};
        trial_ge  = (trial >= {1'b0, step_reg});
        q_big     = ovf_reg | shreg_reg[31];
        if (q_big)
        begin
            acc_val = dneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            acc_val = dneg_reg ? (32'd0 - shreg_reg) : shreg_reg;
        end

        // Drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tvp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next   = pos_diff[32] ? 32'(33'd0 - pos_diff) : pos_diff[31:0];
                    vm_next    = held_reg[31] ? (32'd0 - held_reg) : held_reg;
                    dm_next    = decel_reg[31] ? (32'd0 - decel_reg) : decel_reg;
                    step_next  = in_data.time_step;
                    state_next = tvp_pkg::S_MUL_DIST;
                end
            end
            tvp_pkg::S_MUL_DIST:
            begin
                // Remaining distance times deceleration magnitude
                mul_a      = rem_reg;
                mul_b      = dm_reg;
                state_next = tvp_pkg::S_MUL_STOP;
            end
            tvp_pkg::S_MUL_STOP:
            begin
                // Velocity squared
                dist_next  = prod_reg;
                mul_a      = vm_reg;
                mul_b      = vm_reg;
                state_next = tvp_pkg::S_DECIDE;
            end
            tvp_pkg::S_DECIDE:
            begin
                brake_next = (dm_reg == 32'd0) || (dist_reg <= prod_reg);
                state_next = tvp_pkg::S_MUL_RATE;
            end
            tvp_pkg::S_MUL_RATE:
            begin
                // Rate magnitude times time step
                mul_a      = brake_reg ? dm_reg : {1'b0, accel_reg};
                mul_b      = {16'd0, step_reg};
                state_next = tvp_pkg::S_UPDATE;
            end
            tvp_pkg::S_UPDATE:
            begin
                if (brake_reg)
                begin
                    if (held_reg[31])
                    begin
                        nv_next = 32'd0;
                    end
                    else if ($signed(brake_sum) > $signed(34'sh0_7FFF_FFFF))
                    begin
                        nv_next = 32'h7FFF_FFFF;
                    end
                    else if ($signed(brake_sum) < $signed(-34'sh0_8000_0000))
                    begin
                        nv_next = 32'h8000_0000;
                    end
                    else
                    begin
                        nv_next = brake_sum[31:0];
                    end
                end
                else if ($signed(held_reg) < $signed({1'b0, max_speed_reg}))
                begin
                    if ($signed(accel_sum) > $signed({3'b000, max_speed_reg}))
                    begin
                        nv_next = {1'b0, max_speed_reg};
                    end
                    else
                    begin
                        nv_next = accel_sum[31:0];
                    end
                end
                else
                begin
                    nv_next = {1'b0, max_speed_reg};
                end
                state_next = tvp_pkg::S_DIFF;
            end
            tvp_pkg::S_DIFF:
            begin
                dneg_next  = vel_diff[32];
                dmag_next  = vel_diff[32] ? (33'd0 - vel_diff) : vel_diff;
                state_next = tvp_pkg::S_DIV_SETUP;
            end
            tvp_pkg::S_DIV_SETUP:
            begin
                // Quotient of 2^32 or more saturates without dividing
                drem_next  = dmag_reg[31:16];
                shreg_next = {dmag_reg[15:0], 16'd0};
                cnt_next   = '0;
                ovf_next   = 1'b0;
                if (step_reg == 16'd0)
                begin
                    shreg_next = 32'd0;
                    dneg_next  = 1'b0;
                    state_next = tvp_pkg::S_FINISH;
                end
                else if (dmag_reg[32:16] >= {1'b0, step_reg})
                begin
                    ovf_next   = 1'b1;
                    state_next = tvp_pkg::S_FINISH;
                end
                else
                begin
                    state_next = tvp_pkg::S_DIV;
                end
            end
            tvp_pkg::S_DIV:
            begin
                // Produce one quotient bit
                drem_next  = trial_ge ? 16'(trial - {1'b0, step_reg}) : trial[15:0];
                shreg_next = {shreg_reg[30:0], trial_ge};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = tvp_pkg::S_FINISH;
                end
            end
            tvp_pkg::S_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next.new_velocity   = nv_reg;
                    out_next.accel_estimate = acc_val;
                    out_next.step_was_zero  = (step_reg == 16'd0);
                    out_valid_next          = 1'b1;
                    held_next               = nv_reg;
                    state_next              = tvp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tvp_pkg::S_IDLE;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            held_reg      <= 32'd0;
            cnt_reg       <= '0;
            target_reg    <= 32'd0;
            max_speed_reg <= 31'd0;
            accel_reg     <= 31'd0;
            decel_reg     <= tvp_pkg::DECEL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            cnt_reg       <= cnt_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    tvp_pkg::CFG_TARGET_POSITION: target_reg    <= cfg_data;
                    tvp_pkg::CFG_MAX_SPEED:       max_speed_reg <= cfg_data[30:0];
                    tvp_pkg::CFG_ACCEL_RATE:      accel_reg     <= cfg_data[30:0];
                    tvp_pkg::CFG_DECEL_RATE:      decel_reg     <= cfg_data;
                    default:                      target_reg    <= target_reg;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        vm_reg    <= vm_next;
        dm_reg    <= dm_next;
        step_reg  <= step_next;
        prod_reg  <= prod_next;
        dist_reg  <= dist_next;
        brake_reg <= brake_next;
        nv_reg    <= nv_next;
        dmag_reg  <= dmag_next;
        dneg_reg  <= dneg_next;
        ovf_reg   <= ovf_next;
        drem_reg  <= drem_next;
        shreg_reg <= shreg_next;
        out_reg   <= out_next;
    end

    // Divider remainder stays below the divisor
    `TVP_ASSERT_SAME(a_div_rem, state_reg == tvp_pkg::S_DIV, drem_reg < step_reg)
    // A zero time step reports zero acceleration
    `TVP_ASSERT_SAME(a_zero_step, out_valid_reg && out_reg.step_was_zero,
                     out_reg.accel_estimate == 32'sd0)
    // Publishing a result also updates the held velocity
    `TVP_ASSERT_NEXT(a_publish,
                     state_reg == tvp_pkg::S_FINISH && (!out_valid_reg || out_ready),
                     out_valid_reg && held_reg == out_reg.new_velocity)

endmodule
